// ----- rtl/core/llf_pkg.sv -----
package llf_pkg;

  localparam int SAMPLE_BITS        = 24;
  localparam int STATE_BITS         = 32;
  localparam int OVERSAMPLE         = 2;
  localparam int SHAPER_TABLE_DEPTH = 256;
  localparam int FRAC_BITS          = STATE_BITS - 8;
  localparam int SAMPLE_FRAC        = SAMPLE_BITS - 1;
  localparam int IN_SHIFT           = FRAC_BITS - SAMPLE_FRAC;
  localparam int OUT_SHIFT          = FRAC_BITS - SAMPLE_FRAC;

  localparam int TABLE_BITS  = 16;
  localparam int ARITH_BITS  = 36;
  localparam int COEF_BITS   = 24;
  localparam int GAIN_BITS   = 16;
  localparam int PROD_BITS   = ARITH_BITS + COEF_BITS;
  localparam int FRACT_BITS  = 16;
  localparam int INDEX_BITS  = $clog2(SHAPER_TABLE_DEPTH + 1);

  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 24;

  localparam logic [CFG_INDEX_BITS-1:0] REG_STAGE_COEFFICIENT = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FEEDBACK_GAIN     = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIX_LEVEL         = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OUTPUT_GAIN       = 8'd3;

  localparam logic [GAIN_BITS-1:0] OUTPUT_GAIN_RESET = 16'd4096;

  typedef enum logic [1:0] {SH_12, SH_14, SH_16, SH_24} shift_t;

  typedef struct packed {
    logic signed [ARITH_BITS-1:0] a;
    logic [COEF_BITS-1:0]         b;
    shift_t                       sh;
  } mul_req_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_RND, ST_LOOK, ST_SHMUL, ST_SHRND, ST_AVG, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    SP_FB, SP_U, SP_D0, SP_S1, SP_D1, SP_S2, SP_D2, SP_S3, SP_S4, SP_D3,
    SP_W1, SP_W2, SP_DRY
  } step_t;

  typedef logic [TABLE_BITS-1:0] shaper_rom_t [0:SHAPER_TABLE_DEPTH];

  function automatic shaper_rom_t build_shaper_rom();
    shaper_rom_t rom;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned x3;
    longint unsigned t;
    for (int k = 0; k <= SHAPER_TABLE_DEPTH; k++) begin
      x  = ((longint'(k) << 20) + SHAPER_TABLE_DEPTH / 2) / SHAPER_TABLE_DEPTH;
      x2 = (x * x + (64'd1 << 19)) >> 20;
      x3 = (x2 * x + (64'd1 << 19)) >> 20;
      t  = ((x3 << (FRAC_BITS + 1)) + 64'd2400000000) / 64'd4800000000;
      rom[k] = TABLE_BITS'(t);
    end
    return rom;
  endfunction

  localparam shaper_rom_t SHAPER_ROM = build_shaper_rom();

endpackage

// ----- rtl/core/llf_mulq.sv -----
module llf_mulq
  import llf_pkg::*;
(
  input  logic                         clk,
  input  mul_req_t                     req,
  output logic signed [ARITH_BITS-1:0] res
);

  logic [ARITH_BITS-1:0] mag;
  logic [PROD_BITS-1:0]  prod;
  logic                  neg;
  shift_t                sh_r;
  logic [PROD_BITS:0]    sum;
  logic [PROD_BITS:0]    rnd;

  assign mag = req.a[ARITH_BITS-1] ? (~req.a + 1'b1) : req.a;

  always_ff @(posedge clk) begin
    prod <= PROD_BITS'(mag) * PROD_BITS'(req.b);
    neg  <= req.a[ARITH_BITS-1];
    sh_r <= req.sh;
  end

  // round half away from zero on the magnitude
  always_comb begin
    sum = '0;
    rnd = '0;
    unique case (sh_r)
      SH_12: begin
        sum = {1'b0, prod} + ((PROD_BITS+1)'(1) << 11);
        rnd = sum >> 12;
      end
      SH_14: begin
        sum = {1'b0, prod} + ((PROD_BITS+1)'(1) << 13);
        rnd = sum >> 14;
      end
      SH_16: begin
        sum = {1'b0, prod} + ((PROD_BITS+1)'(1) << 15);
        rnd = sum >> 16;
      end
      SH_24: begin
        sum = {1'b0, prod} + ((PROD_BITS+1)'(1) << 23);
        rnd = sum >> 24;
      end
    endcase
    res = neg ? -$signed(rnd[ARITH_BITS-1:0]) : $signed(rnd[ARITH_BITS-1:0]);
  end

endmodule

// ----- rtl/core/ladder_lowpass_filter.sv -----
// Each input transaction runs OVERSAMPLE ladder passes, then the output-gain, mix
// and dry products; in_stall stays high until its result is presented.
// Each ladder pass runs five table shapings and five products through one
// shared multiplier, then averages the last stage for the feedback value.
// Synchronous reset clears filter state and config; output_gain resets to 4096.
module ladder_lowpass_filter
  import llf_pkg::*;
#(
  parameter int OVERSAMPLE = llf_pkg::OVERSAMPLE
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          block_last_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          block_last_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

  localparam int VW = STATE_BITS;
  localparam int AW = ARITH_BITS;
  localparam int PASS_BITS = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
  localparam int PB = VW + INDEX_BITS;
  localparam int RAW_IDX_BITS = PB - (VW - 1);
  localparam logic signed [AW:0] STATE_MAX = (AW+1)'((64'sd1 <<< (VW - 1)) - 1);
  localparam logic signed [AW:0] STATE_MIN = -STATE_MAX - 1;
  localparam logic [AW:0] OUT_POS_MAX = (AW+1)'((64'd1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic [AW:0] OUT_NEG_MAX = (AW+1)'(64'd1 << (SAMPLE_BITS - 1));

  state_t state, state_next;
  step_t  step;
  logic [PASS_BITS-1:0] pass;

  logic [COEF_BITS-1:0] stage_coefficient;
  logic [GAIN_BITS-1:0] feedback_gain;
  logic [GAIN_BITS-1:0] mix_level;
  logic [GAIN_BITS-1:0] output_gain;

  logic signed [VW-1:0] stage_value [4];
  logic signed [VW-1:0] stage_shaped [3];
  logic signed [VW-1:0] last_stage_four;
  logic signed [VW-1:0] feedback_value;

  logic signed [VW-1:0] x_reg;
  logic signed [VW-1:0] u_reg;
  logic signed [VW-1:0] h_reg;
  logic signed [VW-1:0] g_reg;
  logic signed [AW-1:0] acc;
  logic signed [AW:0]   y_reg;
  logic                 last_reg;

  logic [VW-1:0]         sh_m;
  logic                  sh_neg;
  logic [TABLE_BITS-1:0] sh_t0;
  logic [TABLE_BITS-1:0] sh_diff;
  logic [FRACT_BITS-1:0] sh_f;

  mul_req_t             req;
  logic signed [AW-1:0] mres;

  logic signed [VW-1:0]   shp_in;
  logic [VW-1:0]          shp_mag;
  logic [PB-1:0]          shp_p;
  logic [RAW_IDX_BITS-1:0] raw_idx;
  logic                   over;
  logic [INDEX_BITS-1:0]  idx0;
  logic [INDEX_BITS-1:0]  idx1;
  logic [AW-1:0]          c_full;
  logic [VW-1:0]          c_lim;
  logic [VW-1:0]          s_mag;
  logic signed [VW-1:0]   shp_out;

  logic signed [VW-1:0] upd_base;
  logic signed [AW:0]   upd_sum;
  logic signed [VW-1:0] upd_sat;
  logic signed [AW:0]   u_diff;
  logic signed [VW:0]   avg_sum;

  logic [AW:0]             y_mag;
  logic [AW:0]             y_q;
  logic signed [SAMPLE_BITS-1:0] y_out;
  logic                    in_take;
  logic                    out_free;

  function automatic logic signed [VW-1:0] sat_state(logic signed [AW:0] v);
    logic signed [VW-1:0] r;
    if (v > STATE_MAX) r = STATE_MAX[VW-1:0];
    else if (v < STATE_MIN) r = STATE_MIN[VW-1:0];
    else r = v[VW-1:0];
    return r;
  endfunction

  llf_mulq u_mulq (
    .clk (clk),
    .req (req),
    .res (mres)
  );

  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_MUL;
      ST_MUL:   state_next = ST_RND;
      ST_RND: begin
        priority case (step)
          SP_DRY:  state_next = ST_DONE;
          SP_D3:   state_next = ST_AVG;
          SP_W1, SP_W2: state_next = ST_MUL;
          default: state_next = ST_LOOK;
        endcase
      end
      ST_LOOK:  state_next = ST_SHMUL;
      ST_SHMUL: state_next = ST_SHRND;
      ST_SHRND: state_next = (step == SP_S3) ? ST_LOOK : ST_MUL;
      ST_AVG:   state_next = ST_MUL;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs: handshake and multiplier operands
  always_comb begin
    in_stall = (state != ST_IDLE);
    req.a  = AW'($signed({1'b0, sh_diff}));
    req.b  = COEF_BITS'(sh_f);
    req.sh = SH_16;
    unique case (step)
      SP_FB: begin
        req.a = AW'(feedback_value); req.b = COEF_BITS'(feedback_gain); req.sh = SH_14;
      end
      SP_D0: begin
        req.a = AW'(h_reg) - AW'(stage_shaped[0]); req.b = stage_coefficient; req.sh = SH_24;
      end
      SP_D1: begin
        req.a = AW'(h_reg) - AW'(stage_shaped[1]); req.b = stage_coefficient; req.sh = SH_24;
      end
      SP_D2: begin
        req.a = AW'(h_reg) - AW'(stage_shaped[2]); req.b = stage_coefficient; req.sh = SH_24;
      end
      SP_D3: begin
        req.a = AW'(h_reg) - AW'(g_reg); req.b = stage_coefficient; req.sh = SH_24;
      end
      SP_W1: begin
        req.a = AW'(feedback_value); req.b = COEF_BITS'(output_gain); req.sh = SH_12;
      end
      SP_W2: begin
        req.a = acc; req.b = COEF_BITS'(mix_level); req.sh = SH_16;
      end
      SP_DRY: begin
        req.a = AW'(x_reg);
        req.b = COEF_BITS'(17'h10000 - {1'b0, mix_level});
        req.sh = SH_16;
      end
      default: ;
    endcase
  end

  // shaper datapath
  always_comb begin
    unique case (step)
      SP_U:    shp_in = u_reg;
      SP_S1:   shp_in = stage_value[0];
      SP_S2:   shp_in = stage_value[1];
      SP_S3:   shp_in = stage_value[2];
      default: shp_in = stage_value[3];
    endcase
    shp_mag = shp_in[VW-1] ? (~shp_in + 1'b1) : shp_in;
    shp_p   = PB'(shp_mag) * PB'(SHAPER_TABLE_DEPTH);
    raw_idx = shp_p[PB-1:VW-1];
    over    = raw_idx >= RAW_IDX_BITS'(SHAPER_TABLE_DEPTH);
    idx0    = over ? INDEX_BITS'(SHAPER_TABLE_DEPTH) : raw_idx[INDEX_BITS-1:0];
    idx1    = over ? idx0 : idx0 + 1'b1;
    c_full  = AW'(sh_t0) + AW'(mres);
    c_lim   = (c_full > AW'(sh_m)) ? sh_m : c_full[VW-1:0];
    s_mag   = sh_m - c_lim;
    shp_out = sh_neg ? -$signed(s_mag) : $signed(s_mag);
  end

  // ladder update and output shaping
  always_comb begin
    unique case (step)
      SP_D1:   upd_base = stage_value[1];
      SP_D2:   upd_base = stage_value[2];
      SP_D3:   upd_base = stage_value[3];
      default: upd_base = stage_value[0];
    endcase
    upd_sum = (AW+1)'(upd_base) + (AW+1)'(mres);
    upd_sat = sat_state(upd_sum);
    u_diff  = (AW+1)'(x_reg) - (AW+1)'(mres);
    avg_sum = (VW+1)'(stage_value[3]) + (VW+1)'(last_stage_four);
    y_mag   = y_reg[AW] ? (~y_reg + 1'b1) : y_reg;
    y_q     = (y_mag + ((AW+1)'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
    if (!y_reg[AW] && y_q > OUT_POS_MAX) y_out = OUT_POS_MAX[SAMPLE_BITS-1:0];
    else if (y_reg[AW] && y_q > OUT_NEG_MAX) y_out = OUT_NEG_MAX[SAMPLE_BITS-1:0];
    else if (y_reg[AW]) y_out = -$signed(y_q[SAMPLE_BITS-1:0]);
    else y_out = $signed(y_q[SAMPLE_BITS-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      step              <= SP_FB;
      pass              <= '0;
      out_valid         <= 1'b0;
      stage_coefficient <= '0;
      feedback_gain     <= '0;
      mix_level         <= '0;
      output_gain       <= OUTPUT_GAIN_RESET;
      for (int i = 0; i < 4; i++) stage_value[i] <= '0;
      for (int i = 0; i < 3; i++) stage_shaped[i] <= '0;
      last_stage_four   <= '0;
      feedback_value    <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STAGE_COEFFICIENT: stage_coefficient <= cfg_data[COEF_BITS-1:0];
          REG_FEEDBACK_GAIN:     feedback_gain     <= cfg_data[GAIN_BITS-1:0];
          REG_MIX_LEVEL:         mix_level         <= cfg_data[GAIN_BITS-1:0];
          REG_OUTPUT_GAIN:       output_gain       <= cfg_data[GAIN_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall && state != ST_DONE) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            x_reg    <= VW'(sample_in) <<< IN_SHIFT;
            last_reg <= block_last_in;
            step     <= SP_FB;
            pass     <= '0;
          end
        end
        ST_LOOK: begin
          sh_m    <= shp_mag;
          sh_neg  <= shp_in[VW-1];
          sh_t0   <= SHAPER_ROM[idx0];
          sh_diff <= SHAPER_ROM[idx1] - SHAPER_ROM[idx0];
          sh_f    <= over ? '0 : shp_p[VW-2 -: FRACT_BITS];
        end
        ST_SHRND: begin
          unique case (step)
            SP_U:    step <= SP_D0;
            SP_S1:   step <= SP_D1;
            SP_S2:   step <= SP_D2;
            SP_S3:   step <= SP_S4;
            default: step <= SP_D3;
          endcase
          if (step == SP_S4) g_reg <= shp_out;
          else h_reg <= shp_out;
        end
        ST_RND: begin
          unique case (step)
            SP_FB: begin
              u_reg <= sat_state(u_diff);
              step  <= SP_U;
            end
            SP_D0: begin
              stage_value[0] <= upd_sat;
              step <= SP_S1;
            end
            SP_D1: begin
              stage_value[1]  <= upd_sat;
              stage_shaped[0] <= h_reg;
              step <= SP_S2;
            end
            SP_D2: begin
              stage_value[2]  <= upd_sat;
              stage_shaped[1] <= h_reg;
              step <= SP_S3;
            end
            SP_D3: begin
              stage_value[3]  <= upd_sat;
              stage_shaped[2] <= h_reg;
            end
            SP_W1: begin
              acc  <= mres;
              step <= SP_W2;
            end
            SP_W2: begin
              acc  <= mres;
              step <= SP_DRY;
            end
            default: y_reg <= (AW+1)'(mres) + (AW+1)'(acc);
          endcase
        end
        ST_AVG: begin
          feedback_value  <= avg_sum[VW:1];
          last_stage_four <= stage_value[3];
          if (pass == PASS_BITS'(OVERSAMPLE - 1)) begin
            step <= SP_W1;
          end else begin
            step <= SP_FB;
            pass <= pass + 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            sample_out     <= y_out;
            block_last_out <= last_reg;
          end
        end
        default: ;
      endcase
    end
  end

  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    in_take |=> state == ST_MUL && step == SP_FB && pass == '0)
    else $error("transaction did not start a ladder pass");

  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && out_free |=> out_valid && state == ST_IDLE)
    else $error("finished sample not presented");

  a_avg_next: assert property (@(posedge clk) disable iff (rst)
    state == ST_AVG |=> state == ST_MUL && (step == SP_FB || step == SP_W1))
    else $error("bad step after feedback average");

  a_shrnd_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_SHRND |-> $past(state) == ST_SHMUL)
    else $error("shaper rounding out of order");

endmodule
